// ----- sv/gsce_pkg.sv -----
`timescale 1ns / 1ps

package gsce_pkg;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_STOP_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OPACITY    = 2'd1;

  localparam logic [16:0] FRAC_ONE    = 17'h10000;
  localparam logic [8:0]  OPACITY_MAX = 9'd256;

  typedef struct packed {
    logic        func;
    logic [2:0]  stop_index;
    logic [15:0] stop_position;
    logic [7:0]  stop_red;
    logic [7:0]  stop_green;
    logic [7:0]  stop_blue;
    logic [7:0]  stop_alpha;
    logic [15:0] sample_position;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [2:0] segment;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } stop_entry_t;

  localparam int unsigned ENTRY_W = $bits(stop_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_FRAC,
    ST_DIV,
    ST_LERP,
    ST_SCALE,
    ST_DONE
  } state_e;

endpackage

// ----- sv/gsce_ram.sv -----
`timescale 1ns / 1ps

module gsce_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/gradient_stop_color_eval.sv -----
`timescale 1ns / 1ps

// Color ramp evaluator. A word with func = 0 writes one stop (Q0.16 position and RGBA) into
// the stop table in the cycle it is taken and gives no result; a word with func = 1 samples
// the ramp at a Q0.16 position and gives one result word. An evaluation steps through the
// segment search, the loads of the two bounding stops, the fraction, the division (skipped
// when the fraction is 0 or 1), the blends and the scale; its result waits in the done step
// until the previous result is taken. The segment search reads the stop table (separate
// write and read ports) one entry at a time, with a read and a compare step for each entry,
// the local fraction comes from a 16-step restoring divider, and one shared multiply-add
// unit does the four channel blends and the opacity scale one after another. No new word is
// taken while an evaluation is in progress; stop writes are taken back to back.

module gradient_stop_color_eval
  import gsce_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_STOPS);
  localparam int unsigned CNT_W = $clog2(MAX_STOPS + 1) > 4 ? $clog2(MAX_STOPS + 1) : 4;
  localparam int unsigned SEG_W = IDX_W > 3 ? IDX_W : 3;

  state_e             state_q, state_d;
  logic [3:0]         stop_count_q;
  logic [8:0]         opacity_q;
  logic [15:0]        sample_q;
  logic [IDX_W-1:0]   last_seg_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   seg_q;
  stop_entry_t        ent_a_q;
  stop_entry_t        ent_b_q;
  logic [16:0]        rem_q;
  logic [15:0]        den_q;
  logic [15:0]        quo_q;
  logic [3:0]         div_cnt_q;
  logic [16:0]        frac_q;
  logic [1:0]         ch_q;
  logic [7:0]         col_q [4];
  logic               out_valid_q;
  out_word_t          out_q;

  logic               in_accept;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  stop_entry_t        rd_ent;
  logic               out_load;

  logic [CNT_W-1:0]   cnt_ext;
  logic [CNT_W-1:0]   cnt_eff;
  logic [IDX_W-1:0]   last_seg;
  logic [8:0]         op_eff;

  logic signed [16:0] num_s;
  logic signed [16:0] den_s;
  logic [15:0]        num_abs;
  logic [15:0]        den_abs;

  logic [16:0]        div_r2;
  logic               div_ge;

  logic [7:0]         c0_arr [4];
  logic [7:0]         c1_arr [4];
  logic signed [8:0]  mul_a;
  logic signed [17:0] mul_b;
  logic signed [26:0] mul_add;
  logic signed [26:0] mac;
  logic [SEG_W-1:0]   seg_w;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ram_we     = in_accept && (in_data_i.func == FUNC_WRITE) &&
                      ({6'd0, in_data_i.stop_index} < 9'(MAX_STOPS));
  assign ram_waddr  = IDX_W'(in_data_i.stop_index);
  assign rd_ent     = stop_entry_t'(ram_rdata);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  gsce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STOPS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_data_i.stop_position, in_data_i.stop_red, in_data_i.stop_green,
               in_data_i.stop_blue, in_data_i.stop_alpha}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_ext = CNT_W'(stop_count_q);
    if (cnt_ext < CNT_W'(2)) begin
      cnt_eff = CNT_W'(2);
    end else if (cnt_ext > CNT_W'(MAX_STOPS)) begin
      cnt_eff = CNT_W'(MAX_STOPS);
    end else begin
      cnt_eff = cnt_ext;
    end
    last_seg = IDX_W'(cnt_eff - CNT_W'(2));
    op_eff   = (opacity_q > OPACITY_MAX) ? OPACITY_MAX : opacity_q;
  end

  always_comb begin
    num_s   = $signed({1'b0, sample_q}) - $signed({1'b0, ent_a_q.pos});
    den_s   = $signed({1'b0, rd_ent.pos}) - $signed({1'b0, ent_a_q.pos});
    num_abs = num_s[16] ? 16'(-num_s) : num_s[15:0];
    den_abs = den_s[16] ? 16'(-den_s) : den_s[15:0];
    div_r2  = {rem_q[15:0], 1'b0};
    div_ge  = (div_r2 >= {1'b0, den_q});
  end

  always_comb begin
    c0_arr[0] = ent_a_q.red;
    c0_arr[1] = ent_a_q.green;
    c0_arr[2] = ent_a_q.blue;
    c0_arr[3] = ent_a_q.alpha;
    c1_arr[0] = ent_b_q.red;
    c1_arr[1] = ent_b_q.green;
    c1_arr[2] = ent_b_q.blue;
    c1_arr[3] = ent_b_q.alpha;
    if (state_q == ST_SCALE) begin
      mul_a   = $signed({1'b0, col_q[3]});
      mul_b   = $signed({9'd0, op_eff});
      mul_add = '0;
    end else begin
      mul_a   = $signed({1'b0, c1_arr[ch_q]}) - $signed({1'b0, c0_arr[ch_q]});
      mul_b   = $signed({1'b0, frac_q});
      mul_add = $signed({3'd0, c0_arr[ch_q], 16'd0});
    end
    mac = 27'(mul_a) * 27'(mul_b) + mul_add;
  end

  always_comb begin
    state_d   = state_q;
    ram_raddr = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.func == FUNC_EVAL)) begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        state_d = (idx_q == last_seg_q) ? ST_LOAD_A : ST_SCAN_RD;
      end
      ST_LOAD_A: begin
        ram_raddr = seg_q;
        state_d   = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        ram_raddr = seg_q + IDX_W'(1);
        state_d   = ST_FRAC;
      end
      ST_FRAC: begin
        if (den_s != '0 && num_s != '0 && (num_s[16] == den_s[16]) &&
            (num_abs < den_abs)) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_LERP;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 4'd15) begin
          state_d = ST_LERP;
        end
      end
      ST_LERP: begin
        if (ch_q == 2'd3) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= 4'd2;
      opacity_q    <= OPACITY_MAX;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_addr_i == REG_STOP_COUNT) begin
        stop_count_q <= cfg_wdata_i[3:0];
      end
      if (cfg_we_i && cfg_addr_i == REG_OPACITY) begin
        opacity_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sample_q   <= in_data_i.sample_position;
        last_seg_q <= last_seg;
        idx_q      <= '0;
        seg_q      <= '0;
      end
      ST_SCAN_CMP: begin
        if (rd_ent.pos <= sample_q) begin
          seg_q <= idx_q;
        end
        idx_q <= idx_q + IDX_W'(1);
      end
      ST_FRAC: begin
        ent_b_q   <= rd_ent;
        rem_q     <= {1'b0, num_abs};
        den_q     <= den_abs;
        quo_q     <= '0;
        div_cnt_q <= '0;
        ch_q      <= '0;
        if (den_s == '0) begin
          frac_q <= num_s[16] ? 17'd0 : FRAC_ONE;
        end else if (num_s == '0 || num_s[16] != den_s[16]) begin
          frac_q <= '0;
        end else begin
          frac_q <= FRAC_ONE;
        end
      end
      ST_LOAD_B: begin
        ent_a_q <= rd_ent;
      end
      ST_DIV: begin
        rem_q     <= div_ge ? (div_r2 - {1'b0, den_q}) : div_r2;
        quo_q     <= {quo_q[14:0], div_ge};
        div_cnt_q <= div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) begin
          frac_q <= {1'b0, quo_q[14:0], div_ge};
        end
      end
      ST_LERP: begin
        col_q[ch_q] <= mac[23:16];
        ch_q        <= ch_q + 2'd1;
      end
      ST_SCALE: begin
        col_q[3] <= mac[15:8];
      end
      ST_DONE: begin
        if (out_load) begin
          out_q.red     <= col_q[0];
          out_q.green   <= col_q[1];
          out_q.blue    <= col_q[2];
          out_q.alpha   <= col_q[3];
          out_q.segment <= seg_w[2:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign seg_w       = SEG_W'(seg_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_eval_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.func == FUNC_EVAL |=> state_q == ST_SCAN_RD)
    else $error("evaluation did not start the segment search");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.func == FUNC_WRITE |=> state_q == ST_IDLE)
    else $error("stop write left the idle state");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD_A |-> seg_q <= last_seg_q)
    else $error("chosen segment beyond last segment");

  a_frac_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LERP |-> frac_q <= FRAC_ONE)
    else $error("local fraction above one");

  a_result_only_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the done step");
`endif

endmodule
